// ===== rtl/sdrg_pkg.sv =====
package sdrg_pkg;

   // Glyph geometry
   localparam int SEG_COUNT = 9;
   localparam int SEG_IDX_W = 4;
   localparam int DIGIT_W   = 4;
   localparam int COLOR_W   = 32;

   localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

   // Segment codes, in emission order
   localparam logic [SEG_IDX_W-1:0] SEG_TOP       = 4'd0;
   localparam logic [SEG_IDX_W-1:0] SEG_MID       = 4'd1;
   localparam logic [SEG_IDX_W-1:0] SEG_BOT       = 4'd2;
   localparam logic [SEG_IDX_W-1:0] SEG_LEFT_UP   = 4'd3;
   localparam logic [SEG_IDX_W-1:0] SEG_LEFT_LO   = 4'd4;
   localparam logic [SEG_IDX_W-1:0] SEG_CENTRE_UP = 4'd5;
   localparam logic [SEG_IDX_W-1:0] SEG_CENTRE_LO = 4'd6;
   localparam logic [SEG_IDX_W-1:0] SEG_RIGHT_UP  = 4'd7;
   localparam logic [SEG_IDX_W-1:0] SEG_RIGHT_LO  = 4'd8;

   // Divide by ten: (v * 52429) >> 19 is exact for v below 81920
   localparam int DIV10_MULT  = 52429;
   localparam int DIV10_W     = 16;
   localparam int DIV10_SHIFT = 19;

   // Lit segments per digit, bit n set when segment n is drawn
   function automatic logic [SEG_COUNT-1:0] glyph_mask(input logic [DIGIT_W-1:0] digit);
      logic [SEG_COUNT-1:0] mask;
      unique case (digit)
         4'd0:    mask = 9'b110011101;
         4'd1:    mask = 9'b001100000;
         4'd2:    mask = 9'b010010111;
         4'd3:    mask = 9'b110000111;
         4'd4:    mask = 9'b110001010;
         4'd5:    mask = 9'b100001111;
         4'd6:    mask = 9'b100011111;
         4'd7:    mask = 9'b110000001;
         4'd8:    mask = 9'b110011111;
         4'd9:    mask = 9'b110001011;
         default: mask = '0;
      endcase
      return mask;
   endfunction

endpackage

// ===== rtl/sdrg_front.sv =====
module sdrg_front import sdrg_pkg::*; #(
   parameter  int COORD_WIDTH = 12,
   localparam int CW      = COORD_WIDTH,
   localparam int PW      = COORD_WIDTH + 1,
   localparam int REQ_W   = ((DIGIT_W + 4 * COORD_WIDTH + COLOR_W + 7) / 8) * 8,
   localparam int ENTRY_W = 9 * PW + 3 * CW + COLOR_W + SEG_COUNT + 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [REQ_W-1:0]   req_tdata,
   output logic               push,
   output logic [ENTRY_W-1:0] push_data,
   input  logic               queue_full
);

   localparam int SW     = CW + 3;
   localparam int PROD_W = CW + DIV10_W;
   localparam int LW_W   = PROD_W - DIV10_SHIFT;
   localparam logic signed [SW-1:0] ONE_S = SW'(1);

   typedef struct packed {
      logic [COLOR_W-1:0]   color;
      logic [CW-1:0]        vlen;
      logic [CW-1:0]        barlen;
      logic [CW-1:0]        lw;
      logic [PW-1:0]        y_lower;
      logic [PW-1:0]        y_upper;
      logic [PW-1:0]        y_bot;
      logic [PW-1:0]        y_mid;
      logic [PW-1:0]        y_top;
      logic [PW-1:0]        x_right;
      logic [PW-1:0]        x_centre;
      logic [PW-1:0]        x_left;
      logic [PW-1:0]        x_bar;
      logic [SEG_COUNT-1:0] mask;
      logic                 invalid;
   } entry_type;

   function automatic logic [PW-1:0] clamp_pos(input logic signed [SW-1:0] v);
      return v[SW-1] ? '0 : v[PW-1:0];
   endfunction

   function automatic logic [CW-1:0] clamp_len(input logic signed [SW-1:0] v);
      return v[SW-1] ? '0 : v[CW-1:0];
   endfunction

   logic                 s1_valid_ff, s1_valid_in;
   logic [DIGIT_W-1:0]   s1_digit_ff;
   logic [CW-1:0]        s1_x_ff, s1_y_ff, s1_w_ff, s1_h_ff, s1_side_ff;
   logic [COLOR_W-1:0]   s1_color_ff;

   logic                 s2_valid_ff, s2_valid_in;
   logic [DIGIT_W-1:0]   s2_digit_ff;
   logic [CW-1:0]        s2_x_ff, s2_y_ff, s2_w_ff, s2_h_ff;
   logic [COLOR_W-1:0]   s2_color_ff;
   logic [PROD_W-1:0]    s2_prod_ff;

   logic                 advance;
   logic [DIGIT_W-1:0]   in_digit;
   logic [CW-1:0]        in_x, in_y, in_w, in_h;
   logic [COLOR_W-1:0]   in_color;
   logic [LW_W-1:0]      lw_raw;
   logic [CW-1:0]        lw;
   logic signed [SW-1:0] sx, sy, sw, sh, slw, h_half, lw_half, w_dif, w_dif_half;
   entry_type            entry;

   assign in_digit = req_tdata[0 +: DIGIT_W];
   assign in_x     = req_tdata[DIGIT_W +: CW];
   assign in_y     = req_tdata[DIGIT_W + CW +: CW];
   assign in_w     = req_tdata[DIGIT_W + 2 * CW +: CW];
   assign in_h     = req_tdata[DIGIT_W + 3 * CW +: CW];
   assign in_color = req_tdata[DIGIT_W + 4 * CW +: COLOR_W];

   // Stall the whole front while the tail holds an item the queue cannot take
   assign advance     = !(s2_valid_ff && queue_full);
   assign req_tready  = advance;
   assign s1_valid_in = advance ? req_tvalid : s1_valid_ff;
   assign s2_valid_in = advance ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      if (advance && req_tvalid) begin
         s1_digit_ff <= in_digit;
         s1_x_ff     <= in_x;
         s1_y_ff     <= in_y;
         s1_w_ff     <= in_w;
         s1_h_ff     <= in_h;
         s1_color_ff <= in_color;
         s1_side_ff  <= (in_w > in_h) ? in_h : in_w;
      end
      if (advance && s1_valid_ff) begin
         s2_digit_ff <= s1_digit_ff;
         s2_x_ff     <= s1_x_ff;
         s2_y_ff     <= s1_y_ff;
         s2_w_ff     <= s1_w_ff;
         s2_h_ff     <= s1_h_ff;
         s2_color_ff <= s1_color_ff;
         s2_prod_ff  <= PROD_W'(s1_side_ff) * PROD_W'(DIV10_MULT);
      end
   end

   // Stroke width: side / 10, at least one pixel
   assign lw_raw = s2_prod_ff[PROD_W-1:DIV10_SHIFT];
   assign lw     = (lw_raw == '0) ? CW'(1) : {{(CW - LW_W){1'b0}}, lw_raw};

   assign sx      = $signed({3'b000, s2_x_ff});
   assign sy      = $signed({3'b000, s2_y_ff});
   assign sw      = $signed({3'b000, s2_w_ff});
   assign sh      = $signed({3'b000, s2_h_ff});
   assign slw     = $signed({3'b000, lw});
   assign h_half  = sh >>> 1;
   assign lw_half = slw >>> 1;
   assign w_dif   = sw - slw;
   // Halve toward zero
   assign w_dif_half = w_dif[SW-1] ? ((w_dif + ONE_S) >>> 1) : (w_dif >>> 1);

   always_comb begin
      entry.invalid  = (s2_digit_ff > DIGIT_MAX);
      entry.mask     = entry.invalid ? {{(SEG_COUNT - 1){1'b0}}, 1'b1} : glyph_mask(s2_digit_ff);
      entry.color    = s2_color_ff;
      entry.lw       = lw;
      entry.barlen   = clamp_len(sw - slw - slw - slw - slw);
      entry.vlen     = clamp_len(h_half - slw - slw);
      entry.x_bar    = clamp_pos(sx + slw + slw);
      entry.x_left   = clamp_pos(sx);
      entry.x_centre = clamp_pos(sx + w_dif_half);
      entry.x_right  = clamp_pos(sx + w_dif);
      entry.y_top    = clamp_pos(sy);
      entry.y_mid    = clamp_pos(sy + h_half - lw_half);
      entry.y_bot    = clamp_pos(sy + sh - slw);
      entry.y_upper  = clamp_pos(sy + slw);
      entry.y_lower  = clamp_pos(sy + h_half + slw);
   end

   assign push      = s2_valid_ff && !queue_full;
   assign push_data = entry;

endmodule

// ===== rtl/sdrg_queue.sv =====
module sdrg_queue import sdrg_pkg::*; #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data,
   output logic              empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/sdrg_back.sv =====
module sdrg_back import sdrg_pkg::*; #(
   parameter  int COORD_WIDTH = 12,
   localparam int CW      = COORD_WIDTH,
   localparam int PW      = COORD_WIDTH + 1,
   localparam int RSP_W   = ((SEG_IDX_W + 2 * PW + 2 * CW + COLOR_W + 7) / 8) * 8,
   localparam int ENTRY_W = 9 * PW + 3 * CW + COLOR_W + SEG_COUNT + 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               queue_empty,
   input  logic [ENTRY_W-1:0] queue_data,
   output logic               pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [RSP_W-1:0]   rsp_tdata,
   output logic               rsp_tuser,
   output logic               rsp_tlast
);

   localparam int DATA_BITS = SEG_IDX_W + 2 * PW + 2 * CW + COLOR_W;

   typedef struct packed {
      logic [COLOR_W-1:0]   color;
      logic [CW-1:0]        vlen;
      logic [CW-1:0]        barlen;
      logic [CW-1:0]        lw;
      logic [PW-1:0]        y_lower;
      logic [PW-1:0]        y_upper;
      logic [PW-1:0]        y_bot;
      logic [PW-1:0]        y_mid;
      logic [PW-1:0]        y_top;
      logic [PW-1:0]        x_right;
      logic [PW-1:0]        x_centre;
      logic [PW-1:0]        x_left;
      logic [PW-1:0]        x_bar;
      logic [SEG_COUNT-1:0] mask;
      logic                 invalid;
   } entry_type;

   entry_type            cur_ff, cur_in, head;
   logic                 cur_valid_ff, cur_valid_in;
   logic [SEG_COUNT-1:0] rem_ff, rem_in, rem_next;
   logic                 out_valid_ff, out_valid_in;
   logic [RSP_W-1:0]     out_data_ff;
   logic                 out_invalid_ff, out_last_ff;

   logic                 advance, emit, fin, load;
   logic [SEG_IDX_W-1:0] idx;
   logic [PW-1:0]        sel_x, sel_y;
   logic [CW-1:0]        sel_w, sel_h;
   logic [COLOR_W-1:0]   sel_color;
   logic [DATA_BITS-1:0] sel_data;

   assign head = queue_data;

   // Lowest lit segment still to draw
   always_comb begin
      idx = '0;
      for (int i = SEG_COUNT - 1; i >= 0; i--) begin
         if (rem_ff[i]) begin
            idx = SEG_IDX_W'(i);
         end
      end
   end

   assign rem_next = rem_ff & ~({{(SEG_COUNT - 1){1'b0}}, 1'b1} << idx);
   assign fin      = (rem_next == '0);
   assign advance  = !out_valid_ff || rsp_tready;
   assign emit     = advance && cur_valid_ff;
   // Take the next run in the same cycle the current one finishes
   assign load     = (!cur_valid_ff || (emit && fin)) && !queue_empty;
   assign pop      = load;

   always_comb begin
      unique case (idx) inside
         SEG_TOP, SEG_MID, SEG_BOT: begin
            sel_x = cur_ff.x_bar;
            sel_w = cur_ff.barlen;
            sel_h = cur_ff.lw;
         end
         SEG_LEFT_UP, SEG_LEFT_LO: begin
            sel_x = cur_ff.x_left;
            sel_w = cur_ff.lw;
            sel_h = cur_ff.vlen;
         end
         SEG_CENTRE_UP, SEG_CENTRE_LO: begin
            sel_x = cur_ff.x_centre;
            sel_w = cur_ff.lw;
            sel_h = cur_ff.vlen;
         end
         SEG_RIGHT_UP, SEG_RIGHT_LO: begin
            sel_x = cur_ff.x_right;
            sel_w = cur_ff.lw;
            sel_h = cur_ff.vlen;
         end
         default: begin
            sel_x = '0;
            sel_w = '0;
            sel_h = '0;
         end
      endcase
      unique case (idx) inside
         SEG_TOP:                                 sel_y = cur_ff.y_top;
         SEG_MID:                                 sel_y = cur_ff.y_mid;
         SEG_BOT:                                 sel_y = cur_ff.y_bot;
         SEG_LEFT_UP, SEG_CENTRE_UP, SEG_RIGHT_UP: sel_y = cur_ff.y_upper;
         SEG_LEFT_LO, SEG_CENTRE_LO, SEG_RIGHT_LO: sel_y = cur_ff.y_lower;
         default:                                 sel_y = '0;
      endcase
      sel_color = cur_ff.color;
      // A bad digit draws one empty rectangle
      if (cur_ff.invalid) begin
         sel_x     = '0;
         sel_y     = '0;
         sel_w     = '0;
         sel_h     = '0;
         sel_color = '0;
      end
      sel_data = {sel_color, sel_h, sel_w, sel_y, sel_x, idx};
   end

   always_comb begin
      cur_in       = cur_ff;
      rem_in       = rem_ff;
      cur_valid_in = cur_valid_ff;
      if (load) begin
         cur_in       = head;
         rem_in       = head.mask;
         cur_valid_in = 1'b1;
      end else if (emit) begin
         rem_in = rem_next;
         if (fin) begin
            cur_valid_in = 1'b0;
         end
      end
      out_valid_in = advance ? cur_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         out_valid_ff <= out_valid_in;
      end
      cur_ff <= cur_in;
      rem_ff <= rem_in;
      if (emit) begin
         out_data_ff    <= RSP_W'(sel_data);
         out_invalid_ff <= cur_ff.invalid;
         out_last_ff    <= fin;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_invalid_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== rtl/segment_digit_rect_generator_core.sv =====
// A request passes the front registers, run queue and current-run register, then the output.
// Throughput: one rectangle per cycle while rsp_tready is high and a run is queued; an item
//    gives one rectangle per lit segment (2 to 7), a single one for an invalid digit.
// Requests: one per cycle unless the 4-entry run queue is full with the front tail occupied.
// Reset: synchronous, active high; clears the pipeline valid flags, the queue and the
//    output valid. No clearing pass; the block is ready in the cycle after reset falls.
module segment_digit_rect_generator_core import sdrg_pkg::*; #(
   parameter  int COORD_WIDTH = 12,
   localparam int CW    = COORD_WIDTH,
   localparam int PW    = COORD_WIDTH + 1,
   localparam int REQ_W = ((DIGIT_W + 4 * COORD_WIDTH + COLOR_W + 7) / 8) * 8,
   localparam int RSP_W = ((SEG_IDX_W + 2 * PW + 2 * CW + COLOR_W + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // digit, box_x, box_y, box_width, box_height, color; zero padded
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // segment, rect_x, rect_y, rect_width, rect_height, rect_color; zero padded
   output logic [RSP_W-1:0] rsp_tdata,
   // invalid_digit
   output logic             rsp_tuser,
   output logic             rsp_tlast
);

   // One queue entry carries a whole run: every rectangle's corner and size, already
   // clamped, plus the lit-segment mask and the bad-digit flag.
   localparam int ENTRY_W     = 9 * PW + 3 * CW + COLOR_W + SEG_COUNT + 1;
   localparam int QUEUE_DEPTH = 4;

   logic               push, queue_full, pop, queue_empty;
   logic [ENTRY_W-1:0] push_data, queue_data;

   // Front: register the transaction, multiply the shorter side by the reciprocal of ten,
   // then work out every coordinate and length of the run in one go.
   sdrg_front #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push       (push),
      .push_data  (push_data),
      .queue_full (queue_full)
   );

   // Decouple the front from the output: runs wait here while rectangles drain.
   sdrg_queue #(
      .DATA_W (ENTRY_W),
      .DEPTH  (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (queue_data),
      .empty     (queue_empty)
   );

   // Back: walk lit segments in order into the output register, one per cycle unless stalled.
   sdrg_back #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .queue_data  (queue_data),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

// ===== rtl/sdrg_checker.sv =====
module sdrg_checker import sdrg_pkg::*; #(
   parameter  int COORD_WIDTH = 12,
   localparam int CW    = COORD_WIDTH,
   localparam int PW    = COORD_WIDTH + 1,
   localparam int REQ_W = ((DIGIT_W + 4 * COORD_WIDTH + COLOR_W + 7) / 8) * 8,
   localparam int RSP_W = ((SEG_IDX_W + 2 * PW + 2 * CW + COLOR_W + 7) / 8) * 8
) (
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic [REQ_W-1:0] req_tdata,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata,
   input logic             rsp_tuser,
   input logic             rsp_tlast
);

   // A stalled rectangle holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)
         && $stable(rsp_tuser))
      else $error("rsp transaction changed while stalled");

   // A bad digit is a run of one
   a_bad_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("invalid digit rectangle not marked last");

   // A bad digit's rectangle is empty
   a_bad_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("invalid digit rectangle not empty");

   // Segment index stays within the glyph
   a_seg_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[SEG_IDX_W-1:0] <= SEG_RIGHT_LO)
      else $error("segment index out of range");

   // Reset empties the output
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

endmodule

bind segment_digit_rect_generator_core sdrg_checker #(
   .COORD_WIDTH (COORD_WIDTH)
) u_sdrg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
